// ----- rtl/hexb_pkg.sv -----
package hexb_pkg;

  // Default sizes of the character store and of the result run
  localparam int MAX_CHARS    = 64;
  localparam int MAX_BYTES    = 16;
  // Upper limit of the store depth; sizes the job descriptor fields
  localparam int MAX_CHARS_HI = 1024;
  localparam int POS_W        = $clog2(MAX_CHARS_HI + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 1'b1;
  localparam logic [CFG_DATA_W-1:0] BYTE_COUNT_RST = 5'd4;

  // Characters of interest
  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_X_LO = 8'h78;  // 'x'
  localparam logic [7:0] CH_X_UP = 8'h58;  // 'X'
  localparam logic [4:0] NIB_NONE = 5'd16;

  // One located digit run, handed from the front to the back
  typedef struct packed {
    logic             bank;
    logic             dropped;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] run;
  } job_t;

  // Buffer bank handed back once the back has read it for the last time
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  // Nibble value of a hex digit, NIB_NONE for any other character
  function automatic logic [4:0] nib_of(input logic [7:0] c);
    logic [4:0] r;
    r = NIB_NONE;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = 5'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = 5'(c - 8'h37);
    end
    return r;
  endfunction

endpackage

// ----- rtl/hexb_ram.sv -----
module hexb_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/hexb_front.sv -----
module hexb_front #(
  parameter int MaxChars = hexb_pkg::MAX_CHARS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    text_char_i,
  input  logic                          last_char_i,
  output logic                          ram_we_o,
  output logic [$clog2(MaxChars):0]     ram_waddr_o,
  output logic [7:0]                    ram_wdata_o,
  output logic                          job_push_o,
  output hexb_pkg::job_t                job_o,
  input  hexb_pkg::rel_t                rel_i
);

  localparam int IdxW    = $clog2(MaxChars);
  localparam int CntW    = $clog2(MaxChars + 1);
  localparam int NumScan = 3;
  localparam int SC_PLAIN = 0;  // scan from the string start
  localparam int SC_UPPER = 1;  // scan after the first "0X"
  localparam int SC_LOWER = 2;  // scan after the first "0x"
  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;
  localparam logic [CntW-1:0] Full = CntW'(MaxChars);

  typedef struct packed {
    logic [1:0]      phase;
    logic [CntW-1:0] start;
    logic [CntW-1:0] run;
  } scan_t;

  logic                bank_q, bank_d;
  logic [1:0]          busy_q, busy_d;
  logic [CntW-1:0]     total_q, total_d;
  logic                drop_q, drop_d;
  logic                prevz_q, prevz_d;
  logic [NumScan-1:0]  act_q, act_u, act_d;
  scan_t               scan_q [NumScan];
  scan_t               scan_u [NumScan];
  scan_t               scan_d [NumScan];
  logic                accept, is_zero, store, drop, ends;
  logic [4:0]          nib;
  int unsigned         sel;

  // Hold off new characters while the current bank is still being read
  assign in_stall_o = busy_q[bank_q];

  always_comb begin
    accept  = in_valid_i && !in_stall_o;
    is_zero = (text_char_i == 8'h00);
    store   = accept && !is_zero && (total_q != Full);
    drop    = accept && !is_zero && (total_q == Full);
    ends    = accept && (is_zero || last_char_i);
    nib     = hexb_pkg::nib_of(text_char_i);

    // Advance every active scan by the stored character
    act_u = act_q;
    for (int s = 0; s < NumScan; s++) begin
      scan_u[s] = scan_q[s];
      if (store && act_q[s]) begin
        case (scan_q[s].phase)
          PH_SKIP: begin
            if (!nib[4]) begin
              scan_u[s].phase = PH_RUN;
              scan_u[s].start = total_q;
              scan_u[s].run   = CntW'(1);
            end
          end
          PH_RUN: begin
            if (!nib[4]) begin
              scan_u[s].run = scan_q[s].run + CntW'(1);
            end else begin
              scan_u[s].phase = PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end

    // Open a prefix scan on its first prefix; it starts at the next character
    if (store && prevz_q && !act_q[SC_UPPER] && text_char_i == hexb_pkg::CH_X_UP) begin
      act_u[SC_UPPER]        = 1'b1;
      scan_u[SC_UPPER].phase = PH_SKIP;
      scan_u[SC_UPPER].start = '0;
      scan_u[SC_UPPER].run   = '0;
    end
    if (store && prevz_q && !act_q[SC_LOWER] && text_char_i == hexb_pkg::CH_X_LO) begin
      act_u[SC_LOWER]        = 1'b1;
      scan_u[SC_LOWER].phase = PH_SKIP;
      scan_u[SC_LOWER].start = '0;
      scan_u[SC_LOWER].run   = '0;
    end

    // Pick the scan by prefix priority
    if (act_u[SC_LOWER]) begin
      sel = SC_LOWER;
    end else if (act_u[SC_UPPER]) begin
      sel = SC_UPPER;
    end else begin
      sel = SC_PLAIN;
    end

    job_push_o    = ends;
    job_o.bank    = bank_q;
    job_o.dropped = drop_q || drop;
    job_o.start   = hexb_pkg::POS_W'(scan_u[sel].start);
    job_o.run     = hexb_pkg::POS_W'(scan_u[sel].run);

    // Next state: a finished string starts afresh in the other bank
    bank_d  = bank_q;
    busy_d  = busy_q;
    total_d = store ? total_q + CntW'(1) : total_q;
    drop_d  = drop_q || drop;
    prevz_d = store ? (text_char_i == hexb_pkg::CH_ZERO) : prevz_q;
    act_d   = act_u;
    for (int s = 0; s < NumScan; s++) begin
      scan_d[s] = scan_u[s];
    end
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (ends) begin
      bank_d         = ~bank_q;
      busy_d[bank_q] = 1'b1;
      total_d        = '0;
      drop_d         = 1'b0;
      prevz_d        = 1'b0;
      act_d          = NumScan'(1) << SC_PLAIN;
      for (int s = 0; s < NumScan; s++) begin
        scan_d[s].phase = PH_SKIP;
        scan_d[s].start = '0;
        scan_d[s].run   = '0;
      end
    end
  end

  // Write the stored character into the current bank
  assign ram_we_o    = store;
  assign ram_waddr_o = {bank_q, total_q[IdxW-1:0]};
  assign ram_wdata_o = text_char_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q  <= 1'b0;
      busy_q  <= '0;
      total_q <= '0;
      drop_q  <= 1'b0;
      prevz_q <= 1'b0;
      act_q   <= NumScan'(1) << SC_PLAIN;
      for (int s = 0; s < NumScan; s++) begin
        scan_q[s] <= '0;
      end
    end else begin
      bank_q  <= bank_d;
      busy_q  <= busy_d;
      total_q <= total_d;
      drop_q  <= drop_d;
      prevz_q <= prevz_d;
      act_q   <= act_d;
      for (int s = 0; s < NumScan; s++) begin
        scan_q[s] <= scan_d[s];
      end
    end
  end

endmodule

// ----- rtl/hexb_job_fifo.sv -----
module hexb_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hexb_pkg::job_t job_i,
  input  logic           pop_i,
  output hexb_pkg::job_t job_o,
  output logic           empty_o
);

  hexb_pkg::job_t mem_q [2];
  logic           wr_q, wr_d;
  logic           rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;

  // Two entries cover one job waiting and one job in the back
  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  assign job_o   = mem_q[rd_q];
  assign empty_o = (cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/hexb_back.sv -----
module hexb_back #(
  parameter int MaxChars = hexb_pkg::MAX_CHARS,
  parameter int MaxBytes = hexb_pkg::MAX_BYTES
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_empty_i,
  input  hexb_pkg::job_t            job_i,
  output logic                      job_pop_o,
  output logic [$clog2(MaxChars):0] ram_raddr_o,
  input  logic [7:0]                ram_rdata_i,
  input  logic [4:0]                byte_count_i,
  input  logic                      reverse_i,
  output hexb_pkg::rel_t            rel_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                data_byte_o,
  output logic                      last_byte_o,
  output logic                      overflow_o
);

  localparam int IdxW = $clog2(MaxChars);
  localparam int CntW = $clog2(MaxChars + 1);
  localparam int NbW  = $clog2(MaxBytes + 1);
  localparam int NW   = (NbW > 5) ? NbW : 5;
  localparam int KW   = (NW + 1 > CntW) ? NW + 1 : CntW;
  localparam int PW   = KW + 1;
  localparam logic [NW-1:0] NMax = NW'(MaxBytes);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]     state_q, state_d;
  hexb_pkg::job_t job_q, job_d;
  logic           rev_q, rev_d;
  logic [KW-1:0]  k_q, k_d;
  logic [KW-1:0]  used_q, used_d;
  logic [KW-1:0]  n2_q, n2_d;
  logic [7:0]     acc_q, acc_d;
  logic           ov_q, ov_d;
  logic [7:0]     data_q, data_d;
  logic           lastb_q, lastb_d;
  logic           ovf_q, ovf_d;

  logic [NW-1:0]  bc_ext, n_sel;
  logic [KW-1:0]  n2_new, run_new;
  logic [PW-1:0]  start_e, run_e, k_e, pos;
  logic [4:0]     nib_full;
  logic [3:0]     nib;
  logic           hi_half;
  logic [7:0]     placed;

  always_comb begin
    // Clamp the byte count to 1..MaxBytes
    bc_ext  = NW'(byte_count_i);
    if (bc_ext == '0) begin
      n_sel = NW'(1);
    end else if (bc_ext > NMax) begin
      n_sel = NMax;
    end else begin
      n_sel = bc_ext;
    end
    n2_new  = KW'({n_sel, 1'b0});
    run_new = KW'(job_i.run[CntW-1:0]);

    // Address of digit k of the run
    start_e = PW'(job_q.start[CntW-1:0]);
    run_e   = PW'(job_q.run[CntW-1:0]);
    k_e     = PW'(k_q);
    pos     = rev_q ? (start_e + run_e - PW'(1) - k_e) : (start_e + k_e);
    ram_raddr_o = {job_q.bank, pos[IdxW-1:0]};

    // Place the nibble; digits past the run pad with zero
    nib_full = hexb_pkg::nib_of(ram_rdata_i);
    nib      = (k_q < used_q) ? nib_full[3:0] : 4'h0;
    hi_half  = (k_q[0] == rev_q);
    placed   = hi_half ? {nib, 4'h0} : {4'h0, nib};

    state_d   = state_q;
    job_d     = job_q;
    rev_d     = rev_q;
    k_d       = k_q;
    used_d    = used_q;
    n2_d      = n2_q;
    acc_d     = acc_q;
    ov_d      = ov_q && out_stall_i;
    data_d    = data_q;
    lastb_d   = lastb_q;
    ovf_d     = ovf_q;
    job_pop_o = 1'b0;
    rel_o     = '0;

    case (state_q)
      ST_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          rev_d     = reverse_i;
          k_d       = '0;
          acc_d     = '0;
          n2_d      = n2_new;
          used_d    = (run_new < n2_new) ? run_new : n2_new;
          state_d   = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d   = acc_q | placed;
        k_d     = k_q + KW'(1);
        state_d = k_q[0] ? ST_OUT : ST_RD;
      end
      ST_OUT: begin
        // Load the byte once the output register is free
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          data_d  = acc_q;
          lastb_d = (k_q == n2_q);
          ovf_d   = job_q.dropped;
          acc_d   = '0;
          if (k_q == n2_q) begin
            rel_o.valid = 1'b1;
            rel_o.bank  = job_q.bank;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;
  assign data_byte_o = data_q;
  assign last_byte_o = lastb_q;
  assign overflow_o  = ovf_q;

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    rev_q  <= rev_d;
    k_q    <= k_d;
    used_q <= used_d;
    n2_q   <= n2_d;
    acc_q  <= acc_d;
    data_q <= data_d;
    lastb_q <= lastb_d;
    ovf_q  <= ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

endmodule

// ----- rtl/hex_text_to_byte_array.sv -----
// Channel   Direction  Signals                                       Handshake
// input     in         text_char_i, last_char_i                      in_valid_i / in_stall_o
// output    out        data_byte_o, last_byte_o, overflow_o          out_valid_o / out_stall_i
// config    in         cfg_idx_i, cfg_wdata_i                        cfg_we_i
//
// A character request is taken when offered and not stalled; the digit run is located while loading.
// A finished string is taken from the job queue by the converter; then each nibble is
// one store read plus one accumulate step, and each byte one output load.
// The store has two banks: the next string loads while the last one converts, and
// the input stalls only when both banks are held. Output stalls hold the converter.
// Reset clears control state only; the store needs no clearing.
module hex_text_to_byte_array #(
  parameter int MaxChars = hexb_pkg::MAX_CHARS,
  parameter int MaxBytes = hexb_pkg::MAX_BYTES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          text_char_i,
  input  logic                                last_char_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          data_byte_o,
  output logic                                last_byte_o,
  output logic                                overflow_o,
  input  logic                                cfg_we_i,
  input  logic [hexb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hexb_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int AddrW = $clog2(MaxChars) + 1;

  logic [4:0]        byte_count_q;
  logic              reverse_q;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic              job_push, job_pop, job_empty;
  hexb_pkg::job_t    job_in, job_out;
  hexb_pkg::rel_t    rel;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= hexb_pkg::BYTE_COUNT_RST;
      reverse_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hexb_pkg::REG_BYTE_COUNT: byte_count_q <= cfg_wdata_i;
        hexb_pkg::REG_REVERSE:    reverse_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  hexb_front #(
    .MaxChars(MaxChars)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .text_char_i(text_char_i),
    .last_char_i(last_char_i),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .job_push_o (job_push),
    .job_o      (job_in),
    .rel_i      (rel)
  );

  // Character store, one bank per string in flight
  hexb_ram #(
    .Width(8),
    .Depth(2 ** AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  hexb_job_fifo u_jobs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .job_i  (job_in),
    .pop_i  (job_pop),
    .job_o  (job_out),
    .empty_o(job_empty)
  );

  hexb_back #(
    .MaxChars(MaxChars),
    .MaxBytes(MaxBytes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .byte_count_i(byte_count_q),
    .reverse_i   (reverse_q),
    .rel_o       (rel),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_byte_o (data_byte_o),
    .last_byte_o (last_byte_o),
    .overflow_o  (overflow_o)
  );

endmodule

// ----- rtl/hexb_checker.sv -----
module hexb_checker #(
  parameter int MaxBytes = hexb_pkg::MAX_BYTES
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] data_byte_o,
  input logic       last_byte_o,
  input logic       overflow_o
);

  localparam int CntW = $clog2(MaxBytes + 1);

  logic            out_acc;
  logic            mid_q, mid_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Track position inside the current result run
  always_comb begin
    out_acc = out_valid_o && !out_stall_i;
    mid_d   = mid_q;
    ovf_d   = ovf_q;
    cnt_d   = cnt_q;
    if (out_acc) begin
      mid_d = !last_byte_o;
      ovf_d = overflow_o;
      cnt_d = last_byte_o ? '0 : cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
      ovf_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      mid_q <= mid_d;
      ovf_q <= ovf_d;
      cnt_q <= cnt_d;
    end
  end

  // A stalled result stays offered unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_byte_o)
      && $stable(last_byte_o) && $stable(overflow_o))
    else $error("result changed while stalled");

  // The drop flag is the same on every byte of one run
  a_ovf_const: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && mid_q |-> overflow_o == ovf_q)
    else $error("overflow flag changed inside a run");

  // A run never exceeds the byte buffer
  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && cnt_q == CntW'(MaxBytes - 1) |-> last_byte_o)
    else $error("result run longer than the byte buffer");

endmodule

bind hex_text_to_byte_array hexb_checker #(
  .MaxBytes(MaxBytes)
) u_hexb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .data_byte_o(data_byte_o),
  .last_byte_o(last_byte_o),
  .overflow_o (overflow_o)
);
